/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for clocked concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge out of reset
`define SPQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int PRIO_W    = 16;
    localparam int OCC_W     = 5;

    // operation carried in the input tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // result kind carried in the output tuser
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic                      ins;
        logic                      rem;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
    } cell_cmd_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, compares it against the
// incoming priority and shifts with its neighbors on insert or remove
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                      clk,
    input  cell_cmd_t                 cmd,
    input  logic                      occupied,
    input  logic                      left_gt,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic        [PRIO_W-1:0]  left_prio,
    input  logic signed [VALUE_W-1:0] right_value,
    input  logic        [PRIO_W-1:0]  right_prio,
    output logic                      gt,
    output logic signed [VALUE_W-1:0] value,
    output logic        [PRIO_W-1:0]  prio
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic        [PRIO_W-1:0]  prio_reg;
    logic        [PRIO_W-1:0]  prio_next;

    // new entry goes ahead of this slot: slot empty or strictly larger key
    assign gt = !occupied || (prio_reg > cmd.prio);

    // shift from right on remove, from left or take new entry on insert
    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (cmd.rem)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
        else if (cmd.ins && gt)
        begin
            if (left_gt)
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
            else
            begin
                value_next = cmd.value;
                prio_next  = cmd.prio;
            end
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

    assign value = value_reg;
    assign prio  = prio_reg;

endmodule

/* rtl/sorted_priority_queue_unit.sv */
// an accepted item's result is written to the output register and shown from the next cycle
// throughput: one item per cycle, insert or remove alike, at any occupancy, while the output is not stalled
// every cell of the chain compares and shifts in the same cycle
// reset clears the fill count and output valid; slot contents stay undefined
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// bounded priority queue kept sorted by ascending priority in a chain of
// compare-and-shift cells; equal priorities leave in arrival order
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [31:0] entry_value, [47:32] entry_priority
    input  logic [0:0]  s_axis_tuser,   // [0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [31:0] removed_value, [47:32] removed_priority,
                                        // [52:48] occupancy, [55:53] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                      accept;
    logic                      in_mode;
    logic                      full;
    logic                      empty;
    cell_cmd_t                 cmd;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   out_status_reg;
    status_t                   out_status_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic signed [VALUE_W-1:0] out_value_next;
    logic        [PRIO_W-1:0]  out_prio_reg;
    logic        [PRIO_W-1:0]  out_prio_next;
    logic        [OCC_W-1:0]   out_occ_reg;
    logic        [OCC_W-1:0]   out_occ_next;

    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic        [PRIO_W-1:0]  cell_prio  [DEPTH];
    logic                      cell_gt    [DEPTH];

    // input handshake, output register frees as it is taken
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_mode       = s_axis_tuser[0];
    assign full          = (count_reg == CNT_W'(DEPTH));
    assign empty         = (count_reg == '0);

    // command to the chain
    always_comb
    begin
        cmd.ins   = accept && (in_mode == MODE_INSERT) && !full;
        cmd.rem   = accept && (in_mode == MODE_REMOVE) && !empty;
        cmd.value = s_axis_tdata[VALUE_W-1:0];
        cmd.prio  = s_axis_tdata[VALUE_W+PRIO_W-1:VALUE_W];
    end

    // chain of cells, slot 0 is the front
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                      left_gt;
            logic signed [VALUE_W-1:0] left_value;
            logic        [PRIO_W-1:0]  left_prio;
            logic signed [VALUE_W-1:0] right_value;
            logic        [PRIO_W-1:0]  right_prio;

            if (gi == 0)
            begin : g_head
                assign left_gt    = 1'b0;
                assign left_value = cell_value[gi];
                assign left_prio  = cell_prio[gi];
            end
            else
            begin : g_body
                assign left_gt    = cell_gt[gi-1];
                assign left_value = cell_value[gi-1];
                assign left_prio  = cell_prio[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_value = cell_value[gi];
                assign right_prio  = cell_prio[gi];
            end
            else
            begin : g_next
                assign right_value = cell_value[gi+1];
                assign right_prio  = cell_prio[gi+1];
            end

            spq_cell u_cell
            (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (CNT_W'(gi) < count_reg),
                .left_gt     (left_gt),
                .left_value  (left_value),
                .left_prio   (left_prio),
                .right_value (right_value),
                .right_prio  (right_prio),
                .gt          (cell_gt[gi]),
                .value       (cell_value[gi]),
                .prio        (cell_prio[gi])
            );
        end
    endgenerate

    // fill count and result
    always_comb
    begin
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_prio_next   = out_prio_reg;
        out_occ_next    = out_occ_reg;
        if (cmd.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rem)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_value_next = '0;
            out_prio_next  = '0;
            out_occ_next   = OCC_W'(count_next);
            if (in_mode == MODE_INSERT)
            begin
                out_status_next = full ? ST_FULL : ST_INSERTED;
            end
            else if (empty)
            begin
                out_status_next = ST_EMPTY;
            end
            else
            begin
                out_status_next = ST_REMOVED;
                out_value_next  = cell_value[0];
                out_prio_next   = cell_prio[0];
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_prio_reg   <= out_prio_next;
        out_occ_reg    <= out_occ_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_occ_reg, out_prio_reg, out_value_reg};

    // checks
    `SPQ_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH),
        "fill count above depth")
    `SPQ_ASSERT_NXT(a_insert_count, clk, rst_n,
        accept && in_mode == MODE_INSERT && !full,
        count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the queue")
    `SPQ_ASSERT_NXT(a_remove_front, clk, rst_n,
        accept && in_mode == MODE_REMOVE && !empty,
        out_status_reg == ST_REMOVED && out_value_reg == $past(cell_value[0]),
        "remove did not return the front entry")
    `SPQ_ASSERT_IMP(a_front_sorted, clk, rst_n, count_reg >= CNT_W'(2),
        cell_prio[0] <= cell_prio[1], "front entries out of order")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the sorted priority queue against a behavioral queue: a directed
// table of edge cases, then random insert-heavy, remove-heavy and balanced bursts under
// three idle patterns and one long output stall
// ----------------------------------------------------------------------------
module testbench;

    import spq_pkg::*;

    localparam int QDEPTH        = DEPTH_DEF;
    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_CYCLES   = 64;
    localparam int STALL_LIMIT   = 4000;
    localparam int DIRECTED_ROWS = 25;
    localparam int PHASE_ITEMS   = 242;

    // one result item, as the block reports it
    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
        logic        [OCC_W-1:0]   occ;
    } queue_result_t;

    // one directed item, with a typed-in result where fixed is set
    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
        logic                      fixed;
        queue_result_t             res;
    } directed_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // [31:0] entry_value, [47:32] entry_priority
    logic [0:0]  s_axis_tuser  = '0;   // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;         // [31:0] removed_value, [47:32] removed_priority,
                                       // [52:48] occupancy
    logic [1:0]  m_axis_tuser;         // [1:0] status

    // behavioral copy of the queue, slot 0 is the front
    logic signed [VALUE_W-1:0] held_value [QDEPTH];
    logic        [PRIO_W-1:0]  held_prio  [QDEPTH];
    int                        held_count = 0;

    queue_result_t awaited_results [$];

    int send_idle_pct  = 20;
    int recv_idle_pct  = 47;
    int stall_req_cnt  = 0;
    int stall_served   = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    int error_count    = 0;
    int checked_count  = 0;
    int removed_count  = 0;
    int empty_count    = 0;
    int full_count     = 0;

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // empty queue, then both extremes in and out again
        '{MODE_REMOVE, 32'h0000_0000, 16'h0000, 1'b1, '{ST_EMPTY,    32'h0, 16'h0, 5'd0}},
        '{MODE_INSERT, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, '{ST_INSERTED, 32'h0, 16'h0, 5'd1}},
        '{MODE_INSERT, 32'h8000_0000, 16'h0000, 1'b1, '{ST_INSERTED, 32'h0, 16'h0, 5'd2}},
        '{MODE_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
          '{ST_REMOVED, 32'h8000_0000, 16'h0000, 5'd1}},
        '{MODE_REMOVE, 32'h0000_0000, 16'h0000, 1'b1,
          '{ST_REMOVED, 32'h7FFF_FFFF, 16'hFFFF, 5'd0}},
        '{MODE_REMOVE, 32'h5555_AAAA, 16'hA5A5, 1'b1, '{ST_EMPTY,    32'h0, 16'h0, 5'd0}},
        // fill to the brim with repeated priorities to check arrival order
        '{MODE_INSERT, 32'h0000_0001, 16'h0005, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0002, 16'h0005, 1'b0, '0},
        '{MODE_INSERT, 32'hFFFF_FFFD, 16'h0003, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_0004, 16'h0005, 1'b0, '0},
        '{MODE_INSERT, 32'h8000_0005, 16'hFFFF, 1'b0, '0},
        '{MODE_INSERT, 32'h7FFF_0006, 16'h0000, 1'b0, '0},
        '{MODE_INSERT, 32'hAAAA_0007, 16'h0003, 1'b0, '0},
        '{MODE_INSERT, 32'h5555_0008, 16'h0005, 1'b0, '0},
        '{MODE_INSERT, 32'h1234_0009, 16'h0008, 1'b0, '0},
        '{MODE_INSERT, 32'hFEDC_000A, 16'h0008, 1'b0, '0},
        '{MODE_INSERT, 32'h0F0F_000B, 16'h0000, 1'b0, '0},
        '{MODE_INSERT, 32'hF0F0_000C, 16'hFFFF, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_000D, 16'h0001, 1'b0, '0},
        '{MODE_INSERT, 32'hFFFF_FFF2, 16'h0005, 1'b0, '0},
        '{MODE_INSERT, 32'h0000_000F, 16'h0003, 1'b0, '0},
        '{MODE_INSERT, 32'h8000_0010, 16'h0002, 1'b0, '0},
        // refused when full, then two removes from the front
        '{MODE_INSERT, 32'h1111_1111, 16'h0000, 1'b1, '{ST_FULL,     32'h0, 16'h0, 5'd16}},
        '{MODE_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, '0},
        '{MODE_REMOVE, 32'h0000_0000, 16'h0000, 1'b0, '0}
    };

    sorted_priority_queue_unit #(
        .DEPTH (QDEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    always #(HALF_PERIOD) clk = ~clk;

    // apply one item to the behavioral queue and return the result it gives
    function automatic queue_result_t sorted_queue_step(
        input logic                      mode,
        input logic signed [VALUE_W-1:0] value,
        input logic        [PRIO_W-1:0]  prio
    );
        queue_result_t res;
        int            pos;
        res = '{ST_INSERTED, '0, '0, '0};
        if (mode == MODE_INSERT)
        begin
            if (held_count >= QDEPTH)
                res.status = ST_FULL;
            else
            begin
                // behind every entry whose priority is not greater
                pos = 0;
                while (pos < held_count && held_prio[pos] <= prio)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_value[i] = held_value[i-1];
                    held_prio[i]  = held_prio[i-1];
                end
                held_value[pos] = value;
                held_prio[pos]  = prio;
                held_count++;
            end
        end
        else if (held_count == 0)
            res.status = ST_EMPTY;
        else
        begin
            res.status = ST_REMOVED;
            res.value  = held_value[0];
            res.prio   = held_prio[0];
            for (int i = 1; i < held_count; i++)
            begin
                held_value[i-1] = held_value[i];
                held_prio[i-1]  = held_prio[i];
            end
            held_count--;
        end
        res.occ = held_count[OCC_W-1:0];
        return res;
    endfunction

    // offer one item, wait for acceptance, then record what it should give
    task automatic send_item(
        input logic                      mode,
        input logic signed [VALUE_W-1:0] value,
        input logic        [PRIO_W-1:0]  prio,
        input logic                      use_fixed,
        input queue_result_t             fixed_res
    );
        queue_result_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {prio, value};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = sorted_queue_step(mode, value, prio);
        awaited_results.push_back(use_fixed ? fixed_res : predicted);
    endtask

    // output side: random ready, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (stall_served != stall_req_cnt)
        begin
            stall_served  <= stall_req_cnt;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        queue_result_t want;
        queue_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{status_t'(m_axis_tuser), m_axis_tdata[31:0], m_axis_tdata[47:32],
                    m_axis_tdata[52:48]};
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result item: status %0d value %h priority %h occupancy %0d",
                       got.status, got.value, got.prio, got.occ);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                checked_count++;
                case (want.status)
                    ST_REMOVED: removed_count++;
                    ST_EMPTY:   empty_count++;
                    ST_FULL:    full_count++;
                    default:    ;
                endcase
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.value !== want.value)
                begin
                    $error("removed_value: expected %h, got %h", want.value, got.value);
                    error_count++;
                end
                if (got.prio !== want.prio)
                begin
                    $error("removed_priority: expected %h, got %h", want.prio, got.prio);
                    error_count++;
                end
                if (got.occ !== want.occ)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occ, got.occ);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d results outstanding", awaited_results.size());
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        logic                      mode;
        logic signed [VALUE_W-1:0] value;
        logic        [PRIO_W-1:0]  prio;
        int                        insert_pct;
        int                        pick;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_item(directed_rows[k].mode, directed_rows[k].value, directed_rows[k].prio,
                      directed_rows[k].fixed, directed_rows[k].res);

        // random bursts: receiver idles most, then sender idles most, then neither
        insert_pct = 85;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct <= (phase == 0) ? 20 : (phase == 1) ? 47 : 0;
            recv_idle_pct <= (phase == 0) ? 47 : (phase == 1) ? 20 : 0;
            // long output hold-off so the queue backs up into its input
            if (phase == 2)
                stall_req_cnt <= stall_req_cnt + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // swing between filling and draining
                if (n % 30 == 0)
                begin
                    pick       = $urandom_range(2);
                    insert_pct = (pick == 0) ? 85 : (pick == 1) ? 15 : 55;
                end
                mode = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
                value = $urandom;
                if ($urandom_range(19) == 0)
                    value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                pick = $urandom_range(9);
                if (pick < 4)
                    prio = PRIO_W'($urandom_range(16'hFFFF));
                else if (pick < 8)
                    prio = PRIO_W'($urandom_range(7));
                else
                    prio = (pick == 8) ? 16'h0000 : 16'hFFFF;
                send_item(mode, value, prio, 1'b0, '0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain and let the pipeline settle
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("%0d results checked: %0d removals, %0d empty removes, %0d refused inserts",
                 checked_count, removed_count, empty_count, full_count);
        $display("ran under sender idling, receiver idling, none, and a long output stall");
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
